### rtl/core/etw_pkg.sv
package etw_pkg;

   localparam int C_W = 40;

   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   localparam logic REG_SLOPE_ALPHA = 1'b0;

   typedef enum logic [2:0] {
      CRV_LINEAR   = 3'd0,
      CRV_SMOOTH   = 3'd1,
      CRV_SPEEDUP  = 3'd2,
      CRV_SLOWDOWN = 3'd3,
      CRV_WAVE     = 3'd4,
      CRV_ROTATE   = 3'd5
   } curve_type;

   typedef enum logic [1:0] {
      LVL_CURVE,
      LVL_START,
      LVL_TARGET
   } level_sel_type;

   typedef struct packed {
      logic signed [31:0] start_level;
      logic signed [31:0] target_level;
      logic [31:0]        remaining_ms;
      logic               finished;
      level_sel_type      sel;
      logic [2:0]         curve;
   } meta_type;

   function automatic logic [C_W-1:0] mag_of(input logic signed [C_W-1:0] v);
      logic [C_W-1:0] r;
      r = v[C_W-1] ? C_W'(-v) : C_W'(v);
      return r;
   endfunction

endpackage

### rtl/core/etw_divider.sv
module etw_divider #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  etw_pkg::meta_type      in_meta,
   input  logic [31:0]            in_elapsed,
   input  logic [31:0]            in_total,
   output logic                   out_valid,
   output etw_pkg::meta_type      out_meta,
   output logic [T_FRAC_BITS-1:0] out_t
);

   localparam int NS = 32 + T_FRAC_BITS;

   logic                   vld_ff  [NS];
   etw_pkg::meta_type      meta_ff [NS];
   logic [31:0]            rem_ff  [NS];
   logic [31:0]            dvd_ff  [NS];
   logic [31:0]            tot_ff  [NS];
   logic [T_FRAC_BITS-1:0] quo_ff  [NS];

   // one quotient bit per stage, dividend is elapsed shifted up by the fraction width
   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic                   v_src;
      etw_pkg::meta_type      m_src;
      logic [31:0]            rem_src;
      logic [31:0]            dvd_src;
      logic [31:0]            tot_src;
      logic [T_FRAC_BITS-1:0] quo_src;
      logic [32:0]            cand;
      logic [32:0]            diff;
      logic                   ge;
      logic [31:0]            rem_in;
      logic [T_FRAC_BITS-1:0] quo_in;

      if (s == 0) begin : g_first
         assign v_src   = in_valid;
         assign m_src   = in_meta;
         assign rem_src = '0;
         assign dvd_src = in_elapsed;
         assign tot_src = in_total;
         assign quo_src = '0;
      end else begin : g_next
         assign v_src   = vld_ff[s-1];
         assign m_src   = meta_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign dvd_src = dvd_ff[s-1];
         assign tot_src = tot_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      assign cand   = {rem_src, dvd_src[31]};
      assign ge     = cand >= {1'b0, tot_src};
      assign diff   = cand - {1'b0, tot_src};
      assign rem_in = ge ? diff[31:0] : cand[31:0];
      assign quo_in = {quo_src[T_FRAC_BITS-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            meta_ff[s] <= m_src;
            rem_ff[s]  <= rem_in;
            dvd_ff[s]  <= {dvd_src[30:0], 1'b0};
            tot_ff[s]  <= tot_src;
            quo_ff[s]  <= quo_in;
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_meta  = meta_ff[NS-1];
   assign out_t     = quo_ff[NS-1];

endmodule

### rtl/core/etw_curve.sv
module etw_curve #(
   parameter int T_FRAC_BITS        = 16,
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  etw_pkg::meta_type             in_meta,
   input  logic [T_FRAC_BITS-1:0]        in_t,
   input  logic signed [15:0]            slope_alpha,
   output logic                          out_valid,
   output etw_pkg::meta_type             out_meta,
   output logic signed [etw_pkg::C_W-1:0] out_u
);

   localparam int F  = T_FRAC_BITS;
   localparam int CW = etw_pkg::C_W;
   localparam int MW = CW + F + 1;
   localparam int NW = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int PW = 31 + NW;
   localparam int NST = 7;

   typedef logic [30:0] sine_rom_type [SINE_TABLE_ENTRIES+1];

   function automatic sine_rom_type build_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
         x = (64'(etw_pkg::HALF_PI_Q30) * 64'(i) + 64'(SINE_TABLE_ENTRIES / 2))
             / 64'(SINE_TABLE_ENTRIES);
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > longint'(etw_pkg::ONE_Q30)) begin
            sum = longint'(etw_pkg::ONE_Q30);
         end
         if (i > 0 && 31'(sum) < rom[i-1]) begin
            sum = longint'(rom[i-1]);
         end
         rom[i] = 31'(sum);
      end
      rom[0] = '0;
      rom[SINE_TABLE_ENTRIES] = etw_pkg::ONE_Q30;
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_rom();

   logic              vld_ff  [NST];
   etw_pkg::meta_type meta_ff [NST];

   for (genvar s = 0; s < NST; s++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            meta_ff[s] <= (s == 0) ? in_meta : meta_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   // cubic coefficients, Q30
   logic signed [CW-1:0] c1;
   logic signed [CW-1:0] c2;
   logic signed [CW-1:0] c3;
   assign c1 = CW'(slope_alpha) <<< 18;
   assign c2 = (CW'(signed'({1'b0, etw_pkg::ONE_Q30})) * 3) - (c1 <<< 1);
   assign c3 = c1 - (CW'(signed'({1'b0, etw_pkg::ONE_Q30})) <<< 1);

   function automatic logic signed [CW-1:0] round_t(input logic [MW-1:0] m,
                                                    input logic neg);
      logic [MW-1:0]        s;
      logic signed [CW-1:0] v;
      s = m + (MW'(1) << (F - 1));
      v = signed'(s[F +: CW]);
      return neg ? -v : v;
   endfunction

   // stage 1: curve argument, phase, linear value
   logic [F:0]  tc1_ff;
   logic [31:0] q1_ff;
   logic [30:0] ul1_ff;
   logic [F:0]  tc1_in;
   logic [31:0] q1_in;

   assign tc1_in = (in_meta.curve == etw_pkg::CRV_SPEEDUP) ?
                   ((F+1)'(1) << F) - (F+1)'(in_t) : (F+1)'(in_t);
   assign q1_in  = (in_meta.curve == etw_pkg::CRV_SMOOTH) ?
                   (32'(in_t) << (31 - F)) : (32'(in_t) << (32 - F));

   // stage 2
   logic [MW-1:0] m1_ff;
   logic          n1_ff;
   logic [PW-1:0] pos2_ff;
   logic [1:0]    quad2_ff;
   logic [F:0]    tc2_ff;
   logic [30:0]   ul2_ff;
   logic [31:0]   ph;
   logic [30:0]   arg;
   assign ph  = q1_ff + 32'h4000_0000;
   assign arg = ph[30] ? (etw_pkg::ONE_Q30 - 31'(ph[29:0])) : 31'(ph[29:0]);

   // stage 3
   logic signed [CW-1:0] in1_ff;
   logic [30:0]          lo3_ff;
   logic [30:0]          hi3_ff;
   logic [29:0]          frac3_ff;
   logic [1:0]           quad3_ff;
   logic [F:0]           tc3_ff;
   logic [30:0]          ul3_ff;
   logic [NW-1:0]        idx;
   logic [NW-1:0]        idx_hi;
   assign idx    = pos2_ff[30 +: NW];
   assign idx_hi = (idx == NW'(SINE_TABLE_ENTRIES)) ? idx : idx + 1'b1;

   // stage 4
   logic [MW-1:0] m2_ff;
   logic          n2_ff;
   logic [30:0]   lo4_ff;
   logic [60:0]   dp4_ff;
   logic [1:0]    quad4_ff;
   logic [F:0]    tc4_ff;
   logic [30:0]   ul4_ff;

   // stage 5
   logic signed [CW-1:0] in2_ff;
   logic [30:0]          hv5_ff;
   logic [F:0]           tc5_ff;
   logic [30:0]          ul5_ff;
   logic [30:0]          cm;
   logic signed [32:0]   cs;
   logic signed [32:0]   hsum;
   assign cm   = lo4_ff + 31'(dp4_ff >> 30);
   assign cs   = quad4_ff[1] ? -33'(cm) : 33'(cm);
   assign hsum = 33'(signed'({1'b0, etw_pkg::ONE_Q30})) - cs + 33'sd1;

   // stage 6
   logic [MW-1:0] m3_ff;
   logic          n3_ff;
   logic [30:0]   hv6_ff;
   logic [30:0]   ul6_ff;

   // stage 7
   logic signed [CW-1:0] u7_ff;
   logic signed [CW-1:0] cub;
   logic signed [CW-1:0] u7_in;
   assign cub = round_t(m3_ff, n3_ff);

   always_comb begin
      case (meta_ff[5].curve)
         etw_pkg::CRV_SMOOTH,
         etw_pkg::CRV_WAVE:     u7_in = CW'(hv6_ff);
         etw_pkg::CRV_SPEEDUP:  u7_in = CW'(signed'({1'b0, etw_pkg::ONE_Q30})) - cub;
         etw_pkg::CRV_SLOWDOWN: u7_in = cub;
         default:               u7_in = CW'(ul6_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tc1_ff   <= tc1_in;
         q1_ff    <= q1_in;
         ul1_ff   <= 31'(in_t) << (30 - F);

         m1_ff    <= MW'(etw_pkg::mag_of(c3)) * MW'(tc1_ff);
         n1_ff    <= c3[CW-1];
         pos2_ff  <= PW'(arg) * PW'(SINE_TABLE_ENTRIES);
         quad2_ff <= ph[31:30];
         tc2_ff   <= tc1_ff;
         ul2_ff   <= ul1_ff;

         in1_ff   <= c2 + round_t(m1_ff, n1_ff);
         lo3_ff   <= SINE_ROM[idx];
         hi3_ff   <= SINE_ROM[idx_hi];
         frac3_ff <= pos2_ff[29:0];
         quad3_ff <= quad2_ff;
         tc3_ff   <= tc2_ff;
         ul3_ff   <= ul2_ff;

         m2_ff    <= MW'(etw_pkg::mag_of(in1_ff)) * MW'(tc3_ff);
         n2_ff    <= in1_ff[CW-1];
         lo4_ff   <= lo3_ff;
         dp4_ff   <= 61'(hi3_ff - lo3_ff) * 61'(frac3_ff);
         quad4_ff <= quad3_ff;
         tc4_ff   <= tc3_ff;
         ul4_ff   <= ul3_ff;

         in2_ff   <= c1 + round_t(m2_ff, n2_ff);
         hv5_ff   <= hsum[31:1];
         tc5_ff   <= tc4_ff;
         ul5_ff   <= ul4_ff;

         m3_ff    <= MW'(etw_pkg::mag_of(in2_ff)) * MW'(tc5_ff);
         n3_ff    <= in2_ff[CW-1];
         hv6_ff   <= hv5_ff;
         ul6_ff   <= ul5_ff;

         u7_ff    <= u7_in;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_meta  = meta_ff[NST-1];
   assign out_u     = u7_ff;

endmodule

### rtl/core/etw_blend.sv
module etw_blend (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  etw_pkg::meta_type              in_meta,
   input  logic signed [etw_pkg::C_W-1:0] in_u,
   output logic                           out_valid,
   output logic signed [31:0]             out_level,
   output logic                           out_finished,
   output logic [31:0]                    out_remaining
);

   localparam int CW = etw_pkg::C_W;
   localparam int HW = CW - 30;

   logic              vld_ff  [3];
   etw_pkg::meta_type meta_ff [3];

   for (genvar s = 0; s < 3; s++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            meta_ff[s] <= (s == 0) ? in_meta : meta_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   // magnitudes and product sign
   logic signed [32:0] d;
   logic [32:0]        md_in;
   logic [32:0]        md_ff;
   logic [CW-1:0]      mu_ff;
   logic               neg1_ff;
   assign d     = 33'(in_meta.target_level) - 33'(in_meta.start_level);
   assign md_in = d[32] ? 33'(-d) : 33'(d);

   // split product
   logic [62:0]     plo_ff;
   logic [32+HW:0]  phi_ff;
   logic            neg2_ff;

   // rounded magnitude of the step
   logic [63:0]     plo_rnd;
   logic [33+HW:0]  prod_in;
   logic [33+HW:0]  prod_ff;
   logic            neg3_ff;
   assign plo_rnd = 64'(plo_ff) + 64'h2000_0000;
   assign prod_in = (34+HW)'(phi_ff) + (34+HW)'(plo_rnd >> 30);

   // final level
   logic signed [47:0] lvl;
   logic signed [31:0] sat;
   logic signed [31:0] level_in;
   logic               rsp_valid_ff;
   logic signed [31:0] level_ff;
   logic               finished_ff;
   logic [31:0]        remaining_ff;

   assign lvl = neg3_ff ? 48'(meta_ff[2].start_level) - 48'(prod_ff)
                        : 48'(meta_ff[2].start_level) + 48'(prod_ff);

   always_comb begin
      if (lvl > 48'sh7FFF_FFFF) begin
         sat = 32'sh7FFF_FFFF;
      end else if (lvl < -48'sh8000_0000) begin
         sat = 32'sh8000_0000;
      end else begin
         sat = lvl[31:0];
      end
      case (meta_ff[2].sel)
         etw_pkg::LVL_TARGET: level_in = meta_ff[2].target_level;
         etw_pkg::LVL_START:  level_in = meta_ff[2].start_level;
         default:             level_in = sat;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         md_ff        <= md_in;
         mu_ff        <= etw_pkg::mag_of(in_u);
         neg1_ff      <= d[32] != in_u[CW-1];

         plo_ff       <= 63'(md_ff) * 63'(mu_ff[29:0]);
         phi_ff       <= (33+HW)'(md_ff) * (33+HW)'(mu_ff[CW-1:30]);
         neg2_ff      <= neg1_ff;

         prod_ff      <= prod_in;
         neg3_ff      <= neg2_ff;

         level_ff     <= level_in;
         finished_ff  <= meta_ff[2].finished;
         remaining_ff <= meta_ff[2].remaining_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[2];
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_level     = level_ff;
   assign out_finished  = finished_ff;
   assign out_remaining = remaining_ff;

endmodule

### rtl/core/eased_tween_interpolator.sv
// throughput: one beat per cycle; the whole pipeline holds while a response beat is stalled
// the pipeline runs through the bit-per-stage divider, the cubic multiplier chain and the blend stages
// reset (synchronous, active high) empties the pipeline and clears slope_alpha to zero
module eased_tween_interpolator #(
   parameter int T_FRAC_BITS        = 16,
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_start_level,
   input  logic signed [31:0] req_target_level,
   input  logic [31:0]        req_elapsed_ms,
   input  logic [31:0]        req_total_ms,
   input  logic [2:0]         req_curve,
   input  logic               req_repeats_forever,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_level_out,
   output logic               rsp_finished,
   output logic [31:0]        rsp_remaining_ms,

   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // configuration
   logic signed [15:0] slope_ff;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == etw_pkg::REG_SLOPE_ALPHA) ? 32'(slope_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff <= '0;
      end else if (psel && penable && pwrite && pready &&
                   paddr[2] == etw_pkg::REG_SLOPE_ALPHA) begin
         slope_ff <= pwdata[15:0];
      end
   end

   // special cases resolved on entry
   etw_pkg::meta_type entry_meta;
   logic              done;
   always_comb begin
      done                    = !req_repeats_forever && (req_elapsed_ms >= req_total_ms);
      entry_meta.start_level  = req_start_level;
      entry_meta.target_level = req_target_level;
      entry_meta.remaining_ms = (req_total_ms > req_elapsed_ms) ?
                                req_total_ms - req_elapsed_ms : '0;
      entry_meta.finished     = done;
      entry_meta.curve        = req_curve;
      if (done) begin
         entry_meta.sel = etw_pkg::LVL_TARGET;
      end else if (req_elapsed_ms == '0 || req_total_ms == '0) begin
         entry_meta.sel = etw_pkg::LVL_START;
      end else begin
         entry_meta.sel = etw_pkg::LVL_CURVE;
      end
   end

   logic                          div_valid;
   etw_pkg::meta_type             div_meta;
   logic [T_FRAC_BITS-1:0]        div_t;
   logic                          crv_valid;
   etw_pkg::meta_type             crv_meta;
   logic signed [etw_pkg::C_W-1:0] crv_u;

   etw_divider #(
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .in_meta    (entry_meta),
      .in_elapsed (req_elapsed_ms),
      .in_total   (req_total_ms),
      .out_valid  (div_valid),
      .out_meta   (div_meta),
      .out_t      (div_t)
   );

   etw_curve #(
      .T_FRAC_BITS        (T_FRAC_BITS),
      .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
   ) u_curve (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (div_valid),
      .in_meta     (div_meta),
      .in_t        (div_t),
      .slope_alpha (slope_ff),
      .out_valid   (crv_valid),
      .out_meta    (crv_meta),
      .out_u       (crv_u)
   );

   etw_blend u_blend (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (crv_valid),
      .in_meta       (crv_meta),
      .in_u          (crv_u),
      .out_valid     (rsp_valid),
      .out_level     (rsp_level_out),
      .out_finished  (rsp_finished),
      .out_remaining (rsp_remaining_ms)
   );

   a_finished_no_time_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_remaining_ms == '0)
      else $error("finished beat with time left");

   a_wave_in_range: assert property (@(posedge clock) disable iff (reset)
      crv_valid && crv_meta.sel == etw_pkg::LVL_CURVE &&
      (crv_meta.curve == etw_pkg::CRV_SMOOTH || crv_meta.curve == etw_pkg::CRV_WAVE)
      |-> crv_u >= 0 && crv_u <= 40'sd1073741824)
      else $error("cosine curve out of range");

   a_linear_below_one: assert property (@(posedge clock) disable iff (reset)
      crv_valid && crv_meta.sel == etw_pkg::LVL_CURVE &&
      (crv_meta.curve == etw_pkg::CRV_LINEAR || crv_meta.curve == etw_pkg::CRV_ROTATE)
      |-> crv_u >= 0 && crv_u < 40'sd1073741824)
      else $error("linear curve out of range");

endmodule

### tb/tb_eased_tween_interpolator.sv
module tb_eased_tween_interpolator;

   typedef struct {
      logic signed [31:0] start_level;
      logic signed [31:0] target_level;
      logic [31:0]        elapsed_ms;
      logic [31:0]        total_ms;
      logic [2:0]         curve;
      logic               repeats_forever;
   } tween_req_type;

   typedef struct {
      logic signed [31:0] level_out;
      logic               finished;
      logic [31:0]        remaining_ms;
   } tween_rsp_type;

   localparam int FRAC = 16;
   localparam int LUT_N = 1024;
   localparam longint ONE = 64'sd1 << 30;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_start_level = '0;
   logic signed [31:0] req_target_level = '0;
   logic [31:0]        req_elapsed_ms = '0;
   logic [31:0]        req_total_ms = '0;
   logic [2:0]         req_curve = '0;
   logic               req_repeats_forever = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_level_out;
   logic               rsp_finished;
   logic [31:0]        rsp_remaining_ms;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   logic signed [15:0] cur_alpha;
   logic [31:0]        quarter_lut [0:LUT_N];
   tween_rsp_type      pending_results[$];
   int                 errors = 0;
   bit                 tx_quiet = 1'b0;
   bit                 rx_quiet = 1'b0;
   int                 hold_req = 0;

   eased_tween_interpolator DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void build_quarter_lut();
      longint unsigned x, x2, term;
      longint sum;
      for (int i = 0; i <= LUT_N; i++) begin
         x = (64'd1686629713 * i + LUT_N / 2) / LUT_N;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         if (sum > ONE) sum = ONE;
         if (i > 0 && sum < longint'(quarter_lut[i-1])) sum = longint'(quarter_lut[i-1]);
         quarter_lut[i] = 32'(sum);
      end
      quarter_lut[0] = 32'd0;
      quarter_lut[LUT_N] = 32'h4000_0000;
   endfunction

   function automatic longint quarter_sine(longint unsigned r);
      longint unsigned pos, idx, frac, lo, diff;
      pos = r * LUT_N;
      idx = pos >> 30;
      frac = pos & 64'h3FFF_FFFF;
      if (idx >= LUT_N) return longint'(quarter_lut[LUT_N]);
      lo = quarter_lut[idx];
      diff = quarter_lut[idx+1] - lo;
      return longint'(lo + ((diff * frac) >> 30));
   endfunction

   function automatic longint half_versine(logic [31:0] q);
      logic [31:0] p;
      longint c;
      longint unsigned r;
      p = q + 32'h4000_0000;
      r = p[29:0];
      case (p[31:30])
         2'd0: c = quarter_sine(r);
         2'd1: c = quarter_sine(64'(ONE) - r);
         2'd2: c = -quarter_sine(r);
         default: c = -quarter_sine(64'(ONE) - r);
      endcase
      return (ONE - c + 1) / 2;
   endfunction

   function automatic longint scale_by_t(longint c, longint unsigned t);
      longint unsigned m, p;
      m = (c < 0) ? longint'(-c) : longint'(c);
      p = (m * t + (64'd1 << (FRAC - 1))) >> FRAC;
      return (c < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint ease_cubic(longint unsigned t);
      longint a, c1, c2, c3, in1, in2;
      a = longint'(cur_alpha);
      c1 = a * 262144;
      c2 = 3 * ONE - 2 * c1;
      c3 = c1 - 2 * ONE;
      in1 = c2 + scale_by_t(c3, t);
      in2 = c1 + scale_by_t(in1, t);
      return scale_by_t(in2, t);
   endfunction

   function automatic tween_rsp_type predict_tween(tween_req_type it);
      tween_rsp_type r;
      longint unsigned el, tot, p, t, md, mu, prod;
      longint st, tg, u, d, lvl;
      bit neg;
      el = it.elapsed_ms;
      tot = it.total_ms;
      st = longint'(it.start_level);
      tg = longint'(it.target_level);
      r.finished = !it.repeats_forever && el >= tot;
      r.remaining_ms = (tot > el) ? 32'(tot - el) : 32'd0;
      if (r.finished) lvl = tg;
      else if (el == 0 || tot == 0) lvl = st;
      else begin
         p = it.repeats_forever ? el % tot : el;
         t = (p << FRAC) / tot;
         case (it.curve)
            etw_pkg::CRV_SMOOTH:   u = half_versine(32'(t << (31 - FRAC)));
            etw_pkg::CRV_SPEEDUP:  u = ONE - ease_cubic((64'd1 << FRAC) - t);
            etw_pkg::CRV_SLOWDOWN: u = ease_cubic(t);
            etw_pkg::CRV_WAVE:     u = half_versine(32'(t << (32 - FRAC)));
            default:               u = longint'(t << (30 - FRAC));
         endcase
         d = tg - st;
         neg = (d < 0) != (u < 0);
         md = (d < 0) ? longint'(-d) : longint'(d);
         mu = (u < 0) ? longint'(-u) : longint'(u);
         prod = md * (mu >> 30) + ((md * (mu & 64'h3FFF_FFFF) + (64'd1 << 29)) >> 30);
         lvl = neg ? st - longint'(prod) : st + longint'(prod);
         if (lvl > 64'sd2147483647) lvl = 64'sd2147483647;
         if (lvl < -64'sd2147483648) lvl = -64'sd2147483648;
      end
      r.level_out = 32'(lvl);
      return r;
   endfunction

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (tx_quiet || sel < 55) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver idling, with a long hold-off on request
   always @(posedge clock) begin
      static int left = 0;
      static bit stalling = 1'b0;
      if (hold_req > 0) begin
         left = hold_req;
         hold_req = 0;
         stalling = 1'b1;
      end else if (left > 0) begin
         left--;
      end else if (rx_quiet) begin
         stalling = 1'b0;
      end else begin
         stalling = ($urandom_range(0, 99) < 35);
         left = stalling ? (($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                        : $urandom_range(0, 3))
                         : $urandom_range(0, 12);
      end
      rsp_stall <= stalling;
   end

   always @(posedge clock) begin
      tween_rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected beat: level_out %0d", rsp_level_out);
            errors++;
         end else begin
            exp_r = pending_results[0];
            pending_results.delete(0);
            if (rsp_level_out !== exp_r.level_out) begin
               $error("level_out expected %0d actual %0d", exp_r.level_out, rsp_level_out);
               errors++;
            end
            if (rsp_finished !== exp_r.finished) begin
               $error("finished expected %0d actual %0d", exp_r.finished, rsp_finished);
               errors++;
            end
            if (rsp_remaining_ms !== exp_r.remaining_ms) begin
               $error("remaining_ms expected %0d actual %0d", exp_r.remaining_ms,
                      rsp_remaining_ms);
               errors++;
            end
         end
      end
   end

   task automatic send_beat(input tween_req_type it);
      int gap;
      req_valid <= 1'b1;
      req_start_level <= it.start_level;
      req_target_level <= it.target_level;
      req_elapsed_ms <= it.elapsed_ms;
      req_total_ms <= it.total_ms;
      req_curve <= it.curve;
      req_repeats_forever <= it.repeats_forever;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.insert(pending_results.size(), predict_tween(it));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(input logic [31:0] s, input logic [31:0] g, input logic [31:0] e,
                              input logic [31:0] d, input logic [2:0] c, input logic f);
      tween_req_type it;
      it = '{s, g, e, d, c, f};
      send_beat(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_alpha(input logic signed [15:0] value);
      drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= 3'({etw_pkg::REG_SLOPE_ALPHA, 2'b00});
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cur_alpha = value;
      @(posedge clock);
   endtask

   function automatic tween_req_type random_tween();
      tween_req_type it;
      int sel;
      it.start_level = $urandom;
      it.target_level = $urandom;
      if ($urandom_range(0, 9) == 0) it.start_level = {1'($urandom_range(0, 1)), 31'd0};
      if ($urandom_range(0, 9) == 0) it.target_level = ~it.start_level;
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         it.total_ms = $urandom_range(1, 5000);
         it.elapsed_ms = $urandom_range(0, it.total_ms + it.total_ms / 8);
      end else if (sel < 8) begin
         it.total_ms = $urandom;
         it.elapsed_ms = $urandom;
      end else begin
         it.total_ms = $urandom_range(0, 3);
         it.elapsed_ms = $urandom_range(0, 3);
      end
      it.curve = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
      it.repeats_forever = $urandom_range(0, 3) == 0;
      if (it.repeats_forever && sel < 5) it.elapsed_ms = $urandom;
      return it;
   endfunction

   task automatic test_special_cases();
      send_fields(32'sd100, 32'sd900, 32'd0, 32'd1000, etw_pkg::CRV_LINEAR, 1'b0);
      send_fields(32'sd100, 32'sd900, 32'd1000, 32'd1000, etw_pkg::CRV_SMOOTH, 1'b0);
      send_fields(-32'sd5, 32'sd77, 32'd5000, 32'd1000, etw_pkg::CRV_WAVE, 1'b0);
      send_fields(32'sd1, 32'sd2, 32'd0, 32'd0, etw_pkg::CRV_LINEAR, 1'b0);
      send_fields(32'sd3, 32'sd40, 32'd7, 32'd0, etw_pkg::CRV_WAVE, 1'b1);
      send_fields(32'sd0, 32'sd100000, 32'd2500, 32'd1000, etw_pkg::CRV_WAVE, 1'b1);
      send_fields(32'sd0, 32'sd100000, 32'd3000, 32'd1000, etw_pkg::CRV_SMOOTH, 1'b1);
      for (int c = 0; c < 8; c++)
         send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'd300, 32'd1000, 3'(c), 1'b0);
      send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                  etw_pkg::CRV_SMOOTH, 1'b0);
      send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF,
                  etw_pkg::CRV_SLOWDOWN, 1'b0);
      send_fields(32'sd10, -32'sd10, 32'hFFFF_FFFF, 32'd7, etw_pkg::CRV_SPEEDUP, 1'b1);
      send_fields(32'hFFFF_FFFF, 32'sd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  etw_pkg::CRV_LINEAR, 1'b1);
      send_fields(32'sd0, 32'sd1, 32'd500, 32'd1000, etw_pkg::CRV_ROTATE, 1'b0);
   endtask

   task automatic test_slope_extremes();
      logic signed [15:0] slopes [5];
      slopes = '{16'sh8000, 16'sh7FFF, 16'sd4096, -16'sd4096, 16'sd0};
      foreach (slopes[i]) begin
         write_alpha(slopes[i]);
         for (int n = 0; n < 20; n++) begin
            send_fields(32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(1, 999), 32'd1000,
                        (n % 2) ? etw_pkg::CRV_SPEEDUP : etw_pkg::CRV_SLOWDOWN, 1'b0);
            send_fields($urandom, $urandom, $urandom_range(1, 9999), 32'd1000,
                        3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic test_random_items();
      for (int ph = 0; ph < 6; ph++) begin
         write_alpha(16'($urandom));
         for (int n = 0; n < 200; n++) begin
            if (n % 50 == 0) begin
               tx_quiet = $urandom_range(0, 3) == 0;
               rx_quiet = $urandom_range(0, 3) == 0;
            end
            send_beat(random_tween());
         end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   task automatic test_backpressure();
      drain();
      tx_quiet = 1'b1;
      hold_req = 400;
      for (int n = 0; n < 150; n++) send_beat(random_tween());
      tx_quiet = 1'b0;
   endtask

   initial begin
      cur_alpha = '0;
      build_quarter_lut();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      test_slope_extremes();
      test_random_items();
      test_backpressure();
      drain();
      if (errors == 0) $display("tb_eased_tween_interpolator passed");
      else $display("tb_eased_tween_interpolator failed");
      $finish;
   end

   initial begin
      #30000000;
      $display("tb_eased_tween_interpolator failed");
      $finish;
   end

endmodule
